>>> design/qrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int QRS_COEF_WIDTH = 16;
    localparam int QRS_OUT_W      = 32;
    localparam int QRS_OUT_FRAC   = 16;
    localparam int QRS_LANES      = 3;

    localparam int LANE_SUM  = 0;
    localparam int LANE_DIFF = 1;
    localparam int LANE_IMAG = 2;

    typedef enum logic [1:0] {
        KIND_REAL    = 2'd0,
        KIND_DOUBLE  = 2'd1,
        KIND_COMPLEX = 2'd2,
        KIND_AZERO   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t kind;
        logic  den_neg;
    } front_ctl_t;

    typedef struct packed {
        kind_t                kind;
        logic [QRS_LANES-1:0] neg;
    } post_ctl_t;

endpackage

>>> design/qrs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_front
// Three stages: coefficient magnitudes, products, exact discriminant.
// ----------------------------------------------------------------------------
module qrs_front
    import qrs_pkg::*;
#(
    parameter int W = QRS_COEF_WIDTH
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_vld,
    input  logic [W-1:0]                a,
    input  logic [W-1:0]                b,
    input  logic [W-1:0]                c,
    output logic                        out_vld,
    output front_ctl_t                  ctl,
    output logic [2*W+1:0]              dmag,
    output logic [W+QRS_OUT_FRAC:0]     negb,
    output logic [W:0]                  dm
);

    localparam int DMW = 2 * W + 2;
    localparam int NBW = W + QRS_OUT_FRAC + 1;

    logic [2:0]         vld_reg;
    logic [W-1:0]       ma_reg, mb_reg, mc_reg;
    logic               na_reg, nb_reg, nc_reg;
    logic [W-1:0]       ma2_reg, mb2_reg;
    logic               na2_reg, nb2_reg, nc2_reg;
    logic [2*W-1:0]     p_reg, q_reg;
    front_ctl_t         ctl_reg, ctl_next;
    logic [DMW-1:0]     dmag_reg, dmag_next;
    logic [NBW-1:0]     negb_reg, negb_next;
    logic [W:0]         dm_reg;

    logic [DMW-1:0]     pz, q4;
    logic [NBW-1:0]     mbx;
    logic               dneg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], in_vld};
        end
    end

    always_comb
    begin
        pz        = {2'b00, p_reg};
        q4        = {q_reg, 2'b00};
        dneg      = 1'b0;
        if (na2_reg != nc2_reg || q_reg == '0)
        begin
            dmag_next = pz + q4;
        end
        else if (pz >= q4)
        begin
            dmag_next = pz - q4;
        end
        else
        begin
            dmag_next = q4 - pz;
            dneg      = 1'b1;
        end
        if (ma2_reg == '0)
            ctl_next.kind = KIND_AZERO;
        else if (dmag_next == '0)
            ctl_next.kind = KIND_DOUBLE;
        else if (dneg)
            ctl_next.kind = KIND_COMPLEX;
        else
            ctl_next.kind = KIND_REAL;
        ctl_next.den_neg = na2_reg;
        mbx       = {1'b0, mb2_reg, {QRS_OUT_FRAC{1'b0}}};
        negb_next = nb2_reg ? mbx : (~mbx + 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            na_reg   <= a[W-1];
            nb_reg   <= b[W-1];
            nc_reg   <= c[W-1];
            ma_reg   <= a[W-1] ? (~a + 1'b1) : a;
            mb_reg   <= b[W-1] ? (~b + 1'b1) : b;
            mc_reg   <= c[W-1] ? (~c + 1'b1) : c;

            p_reg    <= mb_reg * mb_reg;
            q_reg    <= ma_reg * mc_reg;
            ma2_reg  <= ma_reg;
            mb2_reg  <= mb_reg;
            na2_reg  <= na_reg;
            nb2_reg  <= nb_reg;
            nc2_reg  <= nc_reg;

            ctl_reg  <= ctl_next;
            dmag_reg <= dmag_next;
            negb_reg <= negb_next;
            dm_reg   <= {ma2_reg, 1'b0};
        end
    end

    assign out_vld = vld_reg[2];
    assign ctl     = ctl_reg;
    assign dmag    = dmag_reg;
    assign negb    = negb_reg;
    assign dm      = dm_reg;

endmodule

>>> design/qrs_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined integer square root, one root bit per stage, sideband carried.
// ----------------------------------------------------------------------------
module qrs_sqrt
    import qrs_pkg::*;
#(
    parameter int RW = QRS_COEF_WIDTH + 17,
    parameter int SW = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_vld,
    input  logic [2*RW-1:0]     x,
    input  logic [SW-1:0]       side_in,
    output logic                out_vld,
    output logic [RW-1:0]       root,
    output logic [SW-1:0]       side_out
);

    localparam int XW  = 2 * RW;
    localparam int RMW = RW + 3;

    logic            vld_reg  [RW];
    logic [RMW-1:0]  rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [XW-1:0]   x_reg    [RW];
    logic [SW-1:0]   side_reg [RW];

    logic            v_in    [RW];
    logic [RMW-1:0]  rem_in  [RW];
    logic [RW-1:0]   root_in [RW];
    logic [XW-1:0]   x_in    [RW];
    logic [SW-1:0]   s_in    [RW];
    logic [RMW-1:0]  r2      [RW];
    logic [RMW-1:0]  trial   [RW];
    logic            ge      [RW];

    always_comb
    begin
        for (int k = 0; k < RW; k++)
        begin
            if (k == 0)
            begin
                v_in[k]    = in_vld;
                rem_in[k]  = '0;
                root_in[k] = '0;
                x_in[k]    = x;
                s_in[k]    = side_in;
            end
            else
            begin
                v_in[k]    = vld_reg[k-1];
                rem_in[k]  = rem_reg[k-1];
                root_in[k] = root_reg[k-1];
                x_in[k]    = x_reg[k-1];
                s_in[k]    = side_reg[k-1];
            end
            r2[k]    = {rem_in[k][RMW-3:0], x_in[k][XW-1 -: 2]};
            trial[k] = {1'b0, root_in[k], 2'b01};
            ge[k]    = r2[k] >= trial[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < RW; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            for (int k = 0; k < RW; k++)
                vld_reg[k] <= v_in[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < RW; k++)
            begin
                rem_reg[k]  <= ge[k] ? (r2[k] - trial[k]) : r2[k];
                root_reg[k] <= {root_in[k][RW-2:0], ge[k]};
                x_reg[k]    <= {x_in[k][XW-3:0], 2'b00};
                side_reg[k] <= s_in[k];
            end
        end
    end

    assign out_vld  = vld_reg[RW-1];
    assign root     = root_reg[RW-1];
    assign side_out = side_reg[RW-1];

endmodule

>>> design/qrs_numer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_numer
// Two stages: signed numerators, then rounding dividends per lane and one shared divisor.
// ----------------------------------------------------------------------------
module qrs_numer
    import qrs_pkg::*;
#(
    parameter int W = QRS_COEF_WIDTH
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_vld,
    input  logic [W+16:0]                       root,
    input  front_ctl_t                          ctl_in,
    input  logic [W+QRS_OUT_FRAC:0]             negb,
    input  logic [W:0]                          dm,
    output logic                                out_vld,
    output logic [QRS_LANES-1:0][W+19:0]        num,
    output logic [W+1:0]                        div,
    output post_ctl_t                           ctl_out
);

    localparam int RW  = W + 17;
    localparam int NBW = W + QRS_OUT_FRAC + 1;
    localparam int NSW = W + 19;
    localparam int NW  = W + 20;
    localparam int DW  = W + 2;

    logic [1:0]                     vld_reg;
    logic [QRS_LANES-1:0][NSW-1:0]  n_reg, n_next;
    front_ctl_t                     ctl1_reg;
    logic [W:0]                     dm1_reg;
    logic [QRS_LANES-1:0][NW-1:0]   num_reg, num_next;
    logic [DW-1:0]                  div_reg;
    post_ctl_t                      ctl_reg, ctl_next;

    logic [NSW-1:0]                 sx, nbx, addend;
    logic [NSW-2:0]                 nm;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[0], in_vld};
        end
    end

    always_comb
    begin
        sx     = NSW'(root);
        nbx    = {{(NSW-NBW){negb[NBW-1]}}, negb};
        addend = (ctl_in.kind == KIND_REAL) ? sx : '0;
        n_next[LANE_SUM]  = nbx + addend;
        n_next[LANE_DIFF] = nbx - addend;
        n_next[LANE_IMAG] = sx;
    end

    always_comb
    begin
        nm            = '0;
        ctl_next.kind = ctl1_reg.kind;
        for (int l = 0; l < QRS_LANES; l++)
        begin
            nm              = n_reg[l][NSW-1] ? (NSW-1)'(~n_reg[l] + 1'b1)
                                              : n_reg[l][NSW-2:0];
            ctl_next.neg[l] = n_reg[l][NSW-1] ^ ctl1_reg.den_neg;
            num_next[l]     = {1'b0, nm, 1'b0} + NW'(dm1_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg    <= n_next;
            ctl1_reg <= ctl_in;
            dm1_reg  <= dm;
            num_reg  <= num_next;
            div_reg  <= {dm1_reg, 1'b0};
            ctl_reg  <= ctl_next;
        end
    end

    assign out_vld = vld_reg[1];
    assign num     = num_reg;
    assign div     = div_reg;
    assign ctl_out = ctl_reg;

endmodule

>>> design/qrs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined restoring divider, lanes sharing one divisor, one bit per stage.
// ----------------------------------------------------------------------------
module qrs_div
    import qrs_pkg::*;
#(
    parameter int NW    = QRS_COEF_WIDTH + 20,
    parameter int DW    = QRS_COEF_WIDTH + 2,
    parameter int LANES = QRS_LANES,
    parameter int SW    = 5
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_vld,
    input  logic [LANES-1:0][NW-1:0]    num,
    input  logic [DW-1:0]               div,
    input  logic [SW-1:0]               side_in,
    output logic                        out_vld,
    output logic [LANES-1:0][NW-1:0]    quo,
    output logic [SW-1:0]               side_out
);

    logic                       vld_reg  [NW];
    logic [LANES-1:0][NW-1:0]   work_reg [NW];
    logic [LANES-1:0][DW-1:0]   rem_reg  [NW];
    logic [DW-1:0]              d_reg    [NW];
    logic [SW-1:0]              side_reg [NW];

    logic                       v_in [NW];
    logic [LANES-1:0][NW-1:0]   w_in [NW];
    logic [LANES-1:0][DW-1:0]   r_in [NW];
    logic [DW-1:0]              d_in [NW];
    logic [SW-1:0]              s_in [NW];
    logic [LANES-1:0][DW:0]     r2   [NW];
    logic [LANES-1:0][DW:0]     diff [NW];
    logic [LANES-1:0]           ge   [NW];

    always_comb
    begin
        for (int k = 0; k < NW; k++)
        begin
            if (k == 0)
            begin
                v_in[k] = in_vld;
                w_in[k] = num;
                r_in[k] = '0;
                d_in[k] = div;
                s_in[k] = side_in;
            end
            else
            begin
                v_in[k] = vld_reg[k-1];
                w_in[k] = work_reg[k-1];
                r_in[k] = rem_reg[k-1];
                d_in[k] = d_reg[k-1];
                s_in[k] = side_reg[k-1];
            end
            for (int l = 0; l < LANES; l++)
            begin
                r2[k][l]   = {r_in[k][l], w_in[k][l][NW-1]};
                diff[k][l] = r2[k][l] - {1'b0, d_in[k]};
                ge[k][l]   = r2[k][l] >= {1'b0, d_in[k]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NW; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            for (int k = 0; k < NW; k++)
                vld_reg[k] <= v_in[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NW; k++)
            begin
                d_reg[k]    <= d_in[k];
                side_reg[k] <= s_in[k];
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[k][l]  <= ge[k][l] ? diff[k][l][DW-1:0] : r2[k][l][DW-1:0];
                    work_reg[k][l] <= {w_in[k][l][NW-2:0], ge[k][l]};
                end
            end
        end
    end

    assign out_vld  = vld_reg[NW-1];
    assign quo      = work_reg[NW-1];
    assign side_out = side_reg[NW-1];

endmodule

>>> design/quadratic_root_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Roots of a*x^2 + b*x + c from fixed-point coefficients, fully pipelined.
// ----------------------------------------------------------------------------
// Input channel: coef_a, coef_b, coef_c with in_valid / in_stall; one
// equation is transferred per cycle when in_valid is high and in_stall low.
// Output channel: both roots as Q16.16 real/imag parts plus root_kind, with
// out_valid / out_stall.
// The pipeline has three front stages, COEF_WIDTH+17 square-root stages (one
// root bit each), two numerator stages, COEF_WIDTH+20 divider stages (one
// quotient bit each) and the saturating output register. Throughput is one
// equation per cycle while out_stall does not hold the pipeline.
// The whole pipeline advances together; when the output register holds a
// result and out_stall is high, every stage holds and in_stall is raised, so
// nothing is dropped or repeated. Reset clears all valid bits; the block
// accepts a transfer in the first cycle after reset.
// ----------------------------------------------------------------------------
module quadratic_root_solver
    import qrs_pkg::*;
#(
    parameter int COEF_WIDTH = QRS_COEF_WIDTH
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [COEF_WIDTH-1:0] coef_a,
    input  logic signed [COEF_WIDTH-1:0] coef_b,
    input  logic signed [COEF_WIDTH-1:0] coef_c,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [QRS_OUT_W-1:0] first_real,
    output logic signed [QRS_OUT_W-1:0] first_imag,
    output logic signed [QRS_OUT_W-1:0] second_real,
    output logic signed [QRS_OUT_W-1:0] second_imag,
    output logic [1:0]                  root_kind
);

    localparam int W    = COEF_WIDTH;
    localparam int DMW  = 2 * W + 2;
    localparam int NBW  = W + QRS_OUT_FRAC + 1;
    localparam int RW   = W + 17;
    localparam int NW   = W + 20;
    localparam int DW   = W + 2;
    localparam int FCW  = $bits(front_ctl_t);
    localparam int PCW  = $bits(post_ctl_t);
    localparam int SSW  = FCW + NBW + W + 1;
    localparam int QX   = (NW > QRS_OUT_W + 1) ? NW : QRS_OUT_W + 1;

    localparam logic [QX-1:0] POS_MAX = QX'({1'b0, {(QRS_OUT_W-1){1'b1}}});
    localparam logic [QX-1:0] NEG_MAX = QX'({1'b1, {(QRS_OUT_W-1){1'b0}}});

    logic                           en;

    logic                           f_vld;
    front_ctl_t                     f_ctl;
    logic [DMW-1:0]                 f_dmag;
    logic [NBW-1:0]                 f_negb;
    logic [W:0]                     f_dm;

    logic                           s_vld;
    logic [RW-1:0]                  s_root;
    logic [SSW-1:0]                 s_side;
    front_ctl_t                     s_ctl;
    logic [NBW-1:0]                 s_negb;
    logic [W:0]                     s_dm;

    logic                           n_vld;
    logic [QRS_LANES-1:0][NW-1:0]   n_num;
    logic [DW-1:0]                  n_div;
    post_ctl_t                      n_ctl;

    logic                           d_vld;
    logic [QRS_LANES-1:0][NW-1:0]   d_quo;
    logic [PCW-1:0]                 d_side;
    post_ctl_t                      d_ctl;

    logic                           out_valid_reg;
    logic [QRS_OUT_W-1:0]           fr_reg, fi_reg, sr_reg, si_reg;
    logic [QRS_OUT_W-1:0]           fr_next, fi_next, sr_next, si_next;
    kind_t                          kind_reg;

    function automatic logic [QRS_OUT_W-1:0] sat_q(input logic [NW-1:0] q, input logic neg);
        logic [QX-1:0] qx;
        logic [QX-1:0] qn;
        qx = QX'(q);
        qn = ~qx + 1'b1;
        if (neg)
            sat_q = (qx > NEG_MAX) ? NEG_MAX[QRS_OUT_W-1:0] : qn[QRS_OUT_W-1:0];
        else
            sat_q = (qx > POS_MAX) ? POS_MAX[QRS_OUT_W-1:0] : qx[QRS_OUT_W-1:0];
    endfunction

    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    qrs_front #(.W(W)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (in_valid),
        .a       (coef_a),
        .b       (coef_b),
        .c       (coef_c),
        .out_vld (f_vld),
        .ctl     (f_ctl),
        .dmag    (f_dmag),
        .negb    (f_negb),
        .dm      (f_dm)
    );

    qrs_sqrt #(.RW(RW), .SW(SSW)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (f_vld),
        .x        ({f_dmag, {(2*QRS_OUT_FRAC){1'b0}}}),
        .side_in  ({f_ctl, f_negb, f_dm}),
        .out_vld  (s_vld),
        .root     (s_root),
        .side_out (s_side)
    );

    assign {s_ctl, s_negb, s_dm} = s_side;

    qrs_numer #(.W(W)) u_numer (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (s_vld),
        .root    (s_root),
        .ctl_in  (s_ctl),
        .negb    (s_negb),
        .dm      (s_dm),
        .out_vld (n_vld),
        .num     (n_num),
        .div     (n_div),
        .ctl_out (n_ctl)
    );

    qrs_div #(.NW(NW), .DW(DW), .LANES(QRS_LANES), .SW(PCW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (n_vld),
        .num      (n_num),
        .div      (n_div),
        .side_in  (n_ctl),
        .out_vld  (d_vld),
        .quo      (d_quo),
        .side_out (d_side)
    );

    assign d_ctl = d_side;

    always_comb
    begin
        fr_next = '0;
        fi_next = '0;
        sr_next = '0;
        si_next = '0;
        case (d_ctl.kind)
            KIND_AZERO:
            begin
                fr_next = '0;
            end
            KIND_COMPLEX:
            begin
                fr_next = sat_q(d_quo[LANE_SUM], d_ctl.neg[LANE_SUM]);
                sr_next = sat_q(d_quo[LANE_DIFF], d_ctl.neg[LANE_DIFF]);
                fi_next = sat_q(d_quo[LANE_IMAG], d_ctl.neg[LANE_IMAG]);
                si_next = sat_q(d_quo[LANE_IMAG], !d_ctl.neg[LANE_IMAG]);
            end
            default:
            begin
                fr_next = sat_q(d_quo[LANE_SUM], d_ctl.neg[LANE_SUM]);
                sr_next = sat_q(d_quo[LANE_DIFF], d_ctl.neg[LANE_DIFF]);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= d_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fr_reg   <= fr_next;
            fi_reg   <= fi_next;
            sr_reg   <= sr_next;
            si_reg   <= si_next;
            kind_reg <= d_ctl.kind;
        end
    end

    assign out_valid   = out_valid_reg;
    assign first_real  = fr_reg;
    assign first_imag  = fi_reg;
    assign second_real = sr_reg;
    assign second_imag = si_reg;
    assign root_kind   = kind_reg;

endmodule

>>> design/qrs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_checker
// Port-level checks of the quadratic root solver, bound to the top level.
// ----------------------------------------------------------------------------
module qrs_checker
    import qrs_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [QRS_OUT_W-1:0]        first_real,
    input  logic [QRS_OUT_W-1:0]        first_imag,
    input  logic [QRS_OUT_W-1:0]        second_real,
    input  logic [QRS_OUT_W-1:0]        second_imag,
    input  logic [1:0]                  root_kind
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_azero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && root_kind == KIND_AZERO |->
            first_real == '0 && first_imag == '0 &&
            second_real == '0 && second_imag == '0)
        else $error("nonzero roots with zero a");

    a_real_imag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (root_kind == KIND_REAL || root_kind == KIND_DOUBLE) |->
            first_imag == '0 && second_imag == '0)
        else $error("imaginary part on real roots");

    a_same_real: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (root_kind == KIND_DOUBLE || root_kind == KIND_COMPLEX) |->
            first_real == second_real)
        else $error("real parts differ");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .first_real  (first_real),
    .first_imag  (first_imag),
    .second_real (second_real),
    .second_imag (second_imag),
    .root_kind   (root_kind)
);
